>>> sv/nested_section_header_parser_macros.svh
// Assertion macros shared by the parser checker
`ifndef NESTED_SECTION_HEADER_PARSER_MACROS_SVH
`define NESTED_SECTION_HEADER_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define NSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define NSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/nsp_pkg.sv
// Types and constants shared by the nested section header parser modules
`timescale 1ns / 1ps

package nsp_pkg;

  localparam int POS_W    = 27;
  localparam int LEN_W    = 26;
  localparam int SIZE_W   = 24;
  localparam int ID_W     = 8;
  localparam int NEST_W   = 5;
  localparam int STATUS_W = 2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [15:0] MAGIC_OPEN  = 16'hFFFE;
  localparam logic [15:0] MAGIC_CLOSE = 16'hFEFF;

  localparam logic KIND_SECTION = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_MAGIC = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NESTING  = 2'd3;

  // One queued step: a first record and an optional trailing status record
  typedef struct packed {
    logic                kind;
    logic [ID_W-1:0]     id;
    logic [SIZE_W-1:0]   size;
    logic [LEN_W-1:0]    offset;
    logic [NEST_W-1:0]   depth;
    logic [STATUS_W-1:0] status;
    logic                has_status;
    logic [STATUS_W-1:0] final_status;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  typedef struct packed {
    logic   avail;
    entry_t entry;
  } head_t;

endpackage

>>> sv/nested_section_header_parser.sv
// Top level of the nested section header parser
`timescale 1ns / 1ps
// A result beat passes through the record queue and then the output register.
// One byte per cycle while the queue has room; the parse state updates once per byte.
// The final byte may give two result beats, which leave one after the other.
// A four-entry queue decouples byte intake from output stall.
// Reset (rst, synchronous, high) clears parser state, the queue and total_length.

module nested_section_header_parser #(
  parameter int MAX_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [nsp_pkg::LEN_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    data_byte,
  input  logic                          last_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          record_kind,
  output logic [nsp_pkg::ID_W-1:0]      section_id,
  output logic [nsp_pkg::SIZE_W-1:0]    section_size,
  output logic [nsp_pkg::LEN_W-1:0]     body_offset,
  output logic [nsp_pkg::NEST_W-1:0]    nest_depth,
  output logic [nsp_pkg::STATUS_W-1:0]  status,
  output logic                          last_result
);

  nsp_pkg::push_t push;
  nsp_pkg::head_t head;
  logic           full;
  logic           pop;

  nsp_front #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .full      (full),
    .push      (push)
  );

  nsp_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (full),
    .head (head)
  );

  nsp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .record_kind  (record_kind),
    .section_id   (section_id),
    .section_size (section_size),
    .body_offset  (body_offset),
    .nest_depth   (nest_depth),
    .status       (status),
    .last_result  (last_result)
  );

endmodule

>>> sv/nsp_front.sv
// Front end: byte intake, word assembly, section parsing and record build
`timescale 1ns / 1ps

module nsp_front #(
  parameter int MAX_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [nsp_pkg::LEN_W-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 data_byte,
  input  logic                       last_byte,
  input  logic                       full,
  output nsp_pkg::push_t             push
);

  localparam int DepthW = $clog2(MAX_DEPTH + 2);

  typedef enum logic [5:0] {
    PH_ROOT_H1  = 6'b000001,
    PH_ROOT_H2  = 6'b000010,
    PH_LOOP_H1  = 6'b000100,
    PH_HDR_H2   = 6'b001000,
    PH_SKIP     = 6'b010000,
    PH_SKIP_ALL = 6'b100000
  } phase_t;

  function automatic logic [nsp_pkg::POS_W-1:0] sat_pos(logic [nsp_pkg::POS_W:0] s);
    return s[nsp_pkg::POS_W] ? '1 : s[nsp_pkg::POS_W-1:0];
  endfunction

  logic [nsp_pkg::LEN_W-1:0]  total_length;
  phase_t                     phase, phase_next;
  logic [23:0]                word_bytes, word_bytes_next;
  logic [1:0]                 byte_in_word, byte_in_word_next;
  logic [nsp_pkg::POS_W-1:0]  byte_position, byte_position_next;
  logic [nsp_pkg::SIZE_W-1:0] iteration_size, iteration_size_next;
  logic [nsp_pkg::SIZE_W-1:0] skip_remaining, skip_remaining_next;
  logic [DepthW-1:0]          open_depth, open_depth_next;
  logic                       finished, finished_next;

  logic                       in_fire;
  logic [31:0]                word;
  logic                       word_done;
  logic                       in_word_phase;
  logic [nsp_pkg::POS_W-1:0]  pos_one, pos_word, pos_end;
  logic                       run_hdr, hdr_at_end;
  logic [31:0]                hdr_word;
  logic [nsp_pkg::POS_W-1:0]  hdr_pos;
  logic [nsp_pkg::POS_W:0]    hdr_end_sum;
  logic                       hdr_size_bad, hdr_no_parent, hdr_too_deep;
  logic [nsp_pkg::SIZE_W-1:0] skip_dec;
  nsp_pkg::entry_t            rec;
  logic                       rec_vld;
  logic [nsp_pkg::STATUS_W-1:0] end_status;

  // Hold input while the queue has no room
  assign in_stall = full;
  assign in_fire  = in_valid && !full;

  // Assemble the little-endian word and the position after this beat
  assign word = {8'b0, word_bytes} | ({24'b0, data_byte} << {byte_in_word, 3'b000});
  assign word_done = (byte_in_word == 2'd3) || last_byte;
  assign in_word_phase = phase inside {PH_ROOT_H1, PH_ROOT_H2, PH_LOOP_H1, PH_HDR_H2};

  assign pos_one  = sat_pos({1'b0, byte_position} + 28'd1);
  assign pos_word = sat_pos({1'b0, byte_position} + (28'd4 - 28'(byte_in_word)));
  assign pos_end  = sat_pos({1'b0, byte_position} + (28'd8 - 28'(byte_in_word)));

  // Header checks: either the id/size word now, or a zero word at the end
  assign hdr_at_end = (phase != PH_HDR_H2);
  assign run_hdr = word_done && ((phase == PH_HDR_H2) ||
                   ((phase == PH_LOOP_H1) && last_byte && (word[15:0] == nsp_pkg::MAGIC_OPEN)));
  assign hdr_word = hdr_at_end ? 32'd0 : word;
  assign hdr_pos  = hdr_at_end ? pos_end : pos_word;
  assign hdr_end_sum = {1'b0, hdr_pos} + {4'b0, hdr_word[31:8]};
  assign hdr_size_bad  = hdr_end_sum > {2'b0, total_length};
  assign hdr_no_parent = (open_depth == '0);
  assign hdr_too_deep  = open_depth > DepthW'(MAX_DEPTH);

  assign skip_dec = (skip_remaining == '0) ? '0 : skip_remaining - 1'b1;

  // Parse one beat
  always_comb begin
    phase_next          = phase;
    word_bytes_next     = word_bytes;
    byte_in_word_next   = byte_in_word;
    byte_position_next  = byte_position;
    iteration_size_next = iteration_size;
    skip_remaining_next = skip_remaining;
    open_depth_next     = open_depth;
    finished_next       = finished;
    rec                 = '0;
    rec_vld             = 1'b0;
    end_status          = nsp_pkg::ST_OK;

    if (in_fire && !finished) begin
      byte_position_next = pos_one;

      if (in_word_phase) begin
        if (word_done) begin
          byte_position_next = pos_word;
          word_bytes_next    = '0;
          byte_in_word_next  = '0;
          case (phase)
            PH_ROOT_H1: begin
              if (last_byte || (word[15:0] != nsp_pkg::MAGIC_OPEN)) begin
                rec.kind      = nsp_pkg::KIND_STATUS;
                rec.status    = nsp_pkg::ST_NO_MAGIC;
                rec_vld       = 1'b1;
                finished_next = 1'b1;
              end else begin
                phase_next = PH_ROOT_H2;
              end
            end
            PH_ROOT_H2: begin
              rec.kind            = nsp_pkg::KIND_SECTION;
              rec.id              = word[7:0];
              rec.size            = word[31:8];
              rec.offset          = pos_word[nsp_pkg::LEN_W-1:0];
              rec_vld             = 1'b1;
              open_depth_next     = DepthW'(1);
              iteration_size_next = 24'd4;
              phase_next          = PH_LOOP_H1;
            end
            PH_LOOP_H1: begin
              if (word[15:0] == nsp_pkg::MAGIC_OPEN) begin
                phase_next = PH_HDR_H2;
                if (last_byte) begin
                  byte_position_next = pos_end;
                end
              end else if ((word[15:0] == nsp_pkg::MAGIC_CLOSE) && (open_depth == '0)) begin
                rec.kind      = nsp_pkg::KIND_STATUS;
                rec.status    = nsp_pkg::ST_NESTING;
                rec_vld       = 1'b1;
                finished_next = 1'b1;
              end else begin
                if (word[15:0] == nsp_pkg::MAGIC_CLOSE) begin
                  open_depth_next = open_depth - 1'b1;
                end
                // Skip the rest of the body of the last header
                if (iteration_size < 24'd4) begin
                  phase_next = PH_SKIP_ALL;
                end else if (iteration_size == 24'd4) begin
                  phase_next = PH_LOOP_H1;
                end else begin
                  phase_next          = PH_SKIP;
                  skip_remaining_next = iteration_size - 24'd4;
                end
              end
            end
            default: ;
          endcase
        end else begin
          word_bytes_next   = word[23:0];
          byte_in_word_next = byte_in_word + 1'b1;
        end
      end else if (phase == PH_SKIP) begin
        skip_remaining_next = skip_dec;
        if (skip_dec == '0) begin
          phase_next          = PH_LOOP_H1;
          iteration_size_next = 24'd4;
        end
      end

      // Check and record one child header
      if (run_hdr) begin
        if (hdr_no_parent) begin
          rec.kind      = nsp_pkg::KIND_STATUS;
          rec.status    = nsp_pkg::ST_NESTING;
          rec_vld       = 1'b1;
          finished_next = 1'b1;
        end else if (hdr_size_bad) begin
          rec.kind      = nsp_pkg::KIND_STATUS;
          rec.status    = nsp_pkg::ST_BAD_SIZE;
          rec_vld       = 1'b1;
          finished_next = 1'b1;
        end else if (hdr_too_deep) begin
          rec.kind      = nsp_pkg::KIND_STATUS;
          rec.status    = nsp_pkg::ST_NESTING;
          rec_vld       = 1'b1;
          finished_next = 1'b1;
        end else begin
          rec.kind            = nsp_pkg::KIND_SECTION;
          rec.id              = hdr_word[7:0];
          rec.size            = hdr_word[31:8];
          rec.offset          = hdr_pos[nsp_pkg::LEN_W-1:0];
          rec.depth           = nsp_pkg::NEST_W'(open_depth);
          rec_vld             = 1'b1;
          open_depth_next     = open_depth + 1'b1;
          iteration_size_next = hdr_word[31:8];
          phase_next          = PH_LOOP_H1;
        end
      end

      // Close the parse on the final byte
      if (last_byte && !finished_next) begin
        end_status    = (open_depth_next != '0) ? nsp_pkg::ST_NESTING : nsp_pkg::ST_OK;
        finished_next = 1'b1;
        if (rec_vld) begin
          rec.has_status   = 1'b1;
          rec.final_status = end_status;
        end else begin
          rec.kind   = nsp_pkg::KIND_STATUS;
          rec.status = end_status;
          rec_vld    = 1'b1;
        end
      end
    end
  end

  assign push.valid = rec_vld;
  assign push.entry = rec;

  // Advance parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      total_length   <= '0;
      phase          <= PH_ROOT_H1;
      word_bytes     <= '0;
      byte_in_word   <= '0;
      byte_position  <= '0;
      iteration_size <= 24'd4;
      skip_remaining <= '0;
      open_depth     <= '0;
      finished       <= 1'b0;
    end else begin
      if (cfg_we) begin
        total_length <= cfg_data;
      end
      phase          <= phase_next;
      word_bytes     <= word_bytes_next;
      byte_in_word   <= byte_in_word_next;
      byte_position  <= byte_position_next;
      iteration_size <= iteration_size_next;
      skip_remaining <= skip_remaining_next;
      open_depth     <= open_depth_next;
      finished       <= finished_next;
    end
  end

endmodule

>>> sv/nsp_fifo.sv
// Short record queue between the parser front end and the output back end
`timescale 1ns / 1ps

module nsp_fifo (
  input  logic            clk,
  input  logic            rst,
  input  nsp_pkg::push_t  push,
  input  logic            pop,
  output logic            full,
  output nsp_pkg::head_t  head
);

  nsp_pkg::entry_t                slots [nsp_pkg::FIFO_DEPTH];
  logic [nsp_pkg::FIFO_AW-1:0]    wr_ptr;
  logic [nsp_pkg::FIFO_AW-1:0]    rd_ptr;
  logic [nsp_pkg::FIFO_CW-1:0]    count;
  logic                           do_pop;

  assign full       = (count == nsp_pkg::FIFO_CW'(nsp_pkg::FIFO_DEPTH));
  assign head.avail = (count != '0);
  assign head.entry = slots[rd_ptr];
  assign do_pop     = pop && head.avail;

  // Store incoming entries
  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push.valid, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> sv/nsp_back.sv
// Back end: split queued entries into output beats and hold the output register
`timescale 1ns / 1ps

module nsp_back (
  input  logic                          clk,
  input  logic                          rst,
  input  nsp_pkg::head_t                head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          record_kind,
  output logic [nsp_pkg::ID_W-1:0]      section_id,
  output logic [nsp_pkg::SIZE_W-1:0]    section_size,
  output logic [nsp_pkg::LEN_W-1:0]     body_offset,
  output logic [nsp_pkg::NEST_W-1:0]    nest_depth,
  output logic [nsp_pkg::STATUS_W-1:0]  status,
  output logic                          last_result
);

  logic slot_free;
  logic beat_sel;
  logic load;

  assign slot_free = !out_valid || !out_stall;
  assign load      = slot_free && head.avail;
  assign pop       = load && (beat_sel || !head.entry.has_status);

  // Track which beat of the head entry goes out next
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      beat_sel  <= 1'b0;
    end else if (slot_free) begin
      out_valid <= head.avail;
      if (load) begin
        beat_sel <= !beat_sel && head.entry.has_status;
      end
    end
  end

  // Load the output beat
  always_ff @(posedge clk) begin
    if (load) begin
      if (beat_sel) begin
        record_kind  <= nsp_pkg::KIND_STATUS;
        section_id   <= '0;
        section_size <= '0;
        body_offset  <= '0;
        nest_depth   <= '0;
        status       <= head.entry.final_status;
        last_result  <= 1'b1;
      end else begin
        record_kind  <= head.entry.kind;
        section_id   <= head.entry.id;
        section_size <= head.entry.size;
        body_offset  <= head.entry.offset;
        nest_depth   <= head.entry.depth;
        status       <= head.entry.status;
        last_result  <= !head.entry.has_status;
      end
    end
  end

endmodule

>>> sv/nsp_props.sv
// Port-level checks for the parser, bound to the top level
`timescale 1ns / 1ps
`include "nested_section_header_parser_macros.svh"

module nsp_props (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          record_kind,
  input logic [nsp_pkg::ID_W-1:0]      section_id,
  input logic [nsp_pkg::SIZE_W-1:0]    section_size,
  input logic [nsp_pkg::LEN_W-1:0]     body_offset,
  input logic [nsp_pkg::NEST_W-1:0]    nest_depth,
  input logic [nsp_pkg::STATUS_W-1:0]  status,
  input logic                          last_result
);

  localparam int BeatW = 1 + nsp_pkg::ID_W + nsp_pkg::SIZE_W + nsp_pkg::LEN_W +
                         nsp_pkg::NEST_W + nsp_pkg::STATUS_W + 1;

  logic [BeatW-1:0] out_beat;
  logic             out_held;
  logic             out_fire;
  logic             is_section;
  logic             is_status;
  logic             is_bare;

  // Gather the output beat and the conditions the checks look at
  assign out_beat   = {record_kind, section_id, section_size, body_offset, nest_depth,
                       status, last_result};
  assign out_held   = out_valid && out_stall;
  assign out_fire   = out_valid && !out_stall;
  assign is_section = out_valid && (record_kind == nsp_pkg::KIND_SECTION);
  assign is_status  = out_valid && (record_kind == nsp_pkg::KIND_STATUS);
  assign is_bare    = (section_id == '0) && (section_size == '0) && (body_offset == '0) &&
                      (nest_depth == '0) && last_result;

  // A stalled output beat stays put
  `NSP_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_beat), "held beat changed")

  // Section records carry no status
  `NSP_ASSERT_NOW(a_section_ok, is_section, status == nsp_pkg::ST_OK, "section with status")

  // Status records are bare and close their beat group
  `NSP_ASSERT_NOW(a_status_bare, is_status, is_bare, "status record not bare")

  // Nothing follows the final status beat
  `NSP_ASSERT_NEXT(a_status_final, out_fire && is_status, !out_valid, "beat after final status")

endmodule

bind nested_section_header_parser nsp_props u_props (.*);
